// File: hw/rtl/mono_bitmap_to_lcd_bytes_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef MONO_BITMAP_TO_LCD_BYTES_MACROS_SVH
`define MONO_BITMAP_TO_LCD_BYTES_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mbl_pkg.sv
package mbl_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned INDEX_W   = 13;
    localparam int unsigned DIM_W     = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned COL_W     = 6;   // stored byte within a row
    localparam int unsigned USED_W    = 7;   // used bytes / stored bytes per row
    localparam int unsigned CNT_W     = 4;   // bytes left in a burst, up to 8
    localparam int unsigned WORD_W    = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 2'd2;

    // Orientation codes
    localparam logic ORIENT_VERTICAL   = 1'b0;
    localparam logic ORIENT_HORIZONTAL = 1'b1;

    // Reset values of the registers
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 9'd128;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 9'd64;

    // Item held between the store read and the write-back
    typedef struct packed {
        logic [BYTE_W-1:0]  row_byte;
        logic               store_en;   // vertical mode, used byte
        logic               clear;      // first row of a page
        logic [2:0]         page_row;
        logic               horiz;
        logic [CNT_W-1:0]   n_bytes;    // results caused by this beat
        logic               img_last;
        logic [INDEX_W-1:0] base_idx;
    } t_s1;

endpackage

// File: hw/rtl/mbl_in_if.sv
interface mbl_in_if import mbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] row_byte;

    modport source (output valid, output row_byte, input ready);
    modport sink   (input valid, input row_byte, output ready);
endinterface

// File: hw/rtl/mbl_out_if.sv
interface mbl_out_if import mbl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic [INDEX_W-1:0] out_index;
    logic               run_last;
    logic               image_last;

    modport source (output valid, output out_byte, output out_index, output run_last,
                    output image_last, input ready);
    modport sink   (input valid, input out_byte, input out_index, input run_last,
                    input image_last, output ready);
endinterface

// File: hw/rtl/mono_bitmap_to_lcd_bytes.sv
// Channel   Dir  Payload                                    Beat
// i_in      in   row_byte                                   one stored bitmap byte
// o_out     out  out_byte, out_index, run_last, image_last  one display byte
// i_cfg_*   in   index, data                                write, no read-back
//
// An input byte is taken each cycle unless the merge stage waits; its page store read
// is registered in the merge stage, where the entry is merged and written back.
// Horizontal bytes leave one per cycle while o_out is ready. A page row burst holds
// up to 8 output beats, so an item that releases output waits while the burst drains.
// Reset is synchronous and needs no clearing pass: the first row of each page
// overwrites its entries. Output stalls back up into the input via the merge stage.
`include "mono_bitmap_to_lcd_bytes_macros.svh"

module mono_bitmap_to_lcd_bytes import mbl_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data,
    mbl_in_if.sink                i_in,
    mbl_out_if.source             o_out
);

    localparam int unsigned PAGE_COLS = (MAX_WIDTH + 7) / 8;
    localparam int unsigned AW        = (PAGE_COLS > 1) ? $clog2(PAGE_COLS) : 1;
    localparam int unsigned DIM_MAX   = (1 << DIM_W) - 1;
    localparam logic [DIM_W-1:0] W_CAP =
        DIM_W'((MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_CAP =
        DIM_W'((MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT);

    // Configuration and position
    logic [DIM_W-1:0] r_image_width, r_image_height;
    logic             r_orient;
    logic [COL_W-1:0] r_byte_in_row, n_byte_in_row;
    logic [DIM_W-1:0] r_row_count, n_row_count;

    // Page store
    logic [WORD_W-1:0] r_page_store [PAGE_COLS];
    logic [WORD_W-1:0] r_rd_data;
    logic [AW-1:0]     rd_addr, r_s1_addr;
    logic              rd_en, wr_en;
    logic [WORD_W-1:0] wr_data;

    // Merge stage
    logic    r_s1_valid;
    t_s1     r_s1, s1_in;
    logic    s1_go;

    // Output burst
    logic [WORD_W-1:0]  r_seq_word, n_seq_word;
    logic [CNT_W-1:0]   r_seq_cnt, n_seq_cnt;
    logic [INDEX_W-1:0] r_seq_idx, n_seq_idx;
    logic               r_seq_img, n_seq_img;
    logic               seq_free, out_beat;

    // Derived geometry
    logic [DIM_W-1:0]    w_eff, h_eff;
    logic [USED_W-1:0]   used_bytes, row_len;
    logic                last_row, used_byte, last_used, page_out;
    logic [DIM_W-1:0]    cols_left;
    logic [DIM_W-1:0]    mul_a, mul_b;
    logic [2*DIM_W-1:0]  product;
    logic [INDEX_W-1:0]  idx_ofs;
    logic [USED_W-1:0]   next_col;
    logic                in_beat;

    // Clamp the dimensions
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_image_width > W_CAP) begin
            w_eff = W_CAP;
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_image_height > H_CAP) begin
            h_eff = H_CAP;
        end else begin
            h_eff = r_image_height;
        end
    end

    // Round up with one spare bit so the widest register value cannot overflow
    assign used_bytes = USED_W'(({1'b0, w_eff} + (DIM_W+1)'(7)) >> 3);
    assign row_len    = USED_W'((({1'b0, w_eff} + (DIM_W+1)'(31)) >> 5) << 2);
    assign last_row   = (r_row_count == h_eff - DIM_W'(1));
    assign used_byte  = (USED_W'(r_byte_in_row) < used_bytes);
    assign last_used  = (USED_W'(r_byte_in_row) == used_bytes - USED_W'(1));
    assign page_out   = (r_row_count[2:0] == 3'd7) || last_row;
    assign cols_left  = w_eff - {r_byte_in_row, 3'b000};

    // Base index: page * width + 8j, or row * used + j
    always_comb begin
        if (r_orient == ORIENT_HORIZONTAL) begin
            mul_a   = r_row_count;
            mul_b   = DIM_W'(used_bytes);
            idx_ofs = INDEX_W'(r_byte_in_row);
        end else begin
            mul_a   = r_row_count >> 3;
            mul_b   = w_eff;
            idx_ofs = INDEX_W'({r_byte_in_row, 3'b000});
        end
    end
    assign product = mul_a * mul_b;

    // Build the merge stage item
    always_comb begin
        s1_in.row_byte = i_in.row_byte;
        s1_in.store_en = (r_orient == ORIENT_VERTICAL) && used_byte;
        s1_in.clear    = (r_row_count[2:0] == 3'd0);
        s1_in.page_row = r_row_count[2:0];
        s1_in.horiz    = (r_orient == ORIENT_HORIZONTAL);
        s1_in.img_last = last_row && last_used;
        s1_in.base_idx = INDEX_W'(product) + idx_ofs;
        if (!used_byte) begin
            s1_in.n_bytes = '0;
        end else if (r_orient == ORIENT_HORIZONTAL) begin
            s1_in.n_bytes = CNT_W'(1);
        end else if (!page_out) begin
            s1_in.n_bytes = '0;
        end else if (cols_left >= DIM_W'(8)) begin
            s1_in.n_bytes = CNT_W'(8);
        end else begin
            s1_in.n_bytes = CNT_W'(cols_left);
        end
    end

    // Handshake
    assign out_beat   = o_out.valid && o_out.ready;
    assign seq_free   = (r_seq_cnt == '0) || ((r_seq_cnt == CNT_W'(1)) && o_out.ready);
    assign s1_go      = r_s1_valid && ((r_s1.n_bytes == '0) || seq_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_beat    = i_in.valid && i_in.ready;

    // Advance the row and column counters
    assign next_col = USED_W'(r_byte_in_row) + USED_W'(1);
    always_comb begin
        n_byte_in_row = r_byte_in_row;
        n_row_count   = r_row_count;
        if (in_beat) begin
            if (next_col >= row_len) begin
                n_byte_in_row = '0;
                if (last_row) begin
                    n_row_count = '0;
                end else begin
                    n_row_count = r_row_count + DIM_W'(1);
                end
            end else begin
                n_byte_in_row = COL_W'(next_col);
            end
        end
    end

    // Configuration registers and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_orient       <= ORIENT_VERTICAL;
            r_byte_in_row  <= '0;
            r_row_count    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                    r_byte_in_row <= '0;
                    r_row_count   <= '0;
                end
                REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                    r_byte_in_row  <= '0;
                    r_row_count    <= '0;
                end
                REG_ORIENTATION: begin
                    r_orient      <= i_cfg_data[0];
                    r_byte_in_row <= '0;
                    r_row_count   <= '0;
                end
                default: begin
                    r_byte_in_row <= n_byte_in_row;
                    r_row_count   <= n_row_count;
                end
            endcase
        end else begin
            r_byte_in_row <= n_byte_in_row;
            r_row_count   <= n_row_count;
        end
    end

    // Page store: read on accept, write back from the merge stage
    assign rd_en   = in_beat && s1_in.store_en;
    assign rd_addr = AW'(r_byte_in_row);
    assign wr_en   = s1_go && r_s1.store_en;

    always_comb begin
        wr_data = r_s1.clear ? '0 : r_rd_data;
        for (int k = 0; k < 8; k++) begin
            if (r_s1.row_byte[7-k]) begin
                wr_data[k*8 + int'(r_s1.page_row)] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_page_store[r_s1_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_page_store[rd_addr];
        end
    end

    // Merge stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1      <= s1_in;
            r_s1_addr <= rd_addr;
        end
    end

    // Output burst: load from the merge stage, shift a byte out per beat
    always_comb begin
        n_seq_word = r_seq_word;
        n_seq_cnt  = r_seq_cnt;
        n_seq_idx  = r_seq_idx;
        n_seq_img  = r_seq_img;
        if (s1_go && (r_s1.n_bytes != '0)) begin
            n_seq_word = r_s1.horiz ? WORD_W'(r_s1.row_byte) : wr_data;
            n_seq_cnt  = r_s1.n_bytes;
            n_seq_idx  = r_s1.base_idx;
            n_seq_img  = r_s1.img_last;
        end else if (out_beat) begin
            n_seq_word = r_seq_word >> 8;
            n_seq_cnt  = r_seq_cnt - CNT_W'(1);
            n_seq_idx  = r_seq_idx + INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_cnt <= '0;
        end else begin
            r_seq_cnt <= n_seq_cnt;
        end
        r_seq_word <= n_seq_word;
        r_seq_idx  <= n_seq_idx;
        r_seq_img  <= n_seq_img;
    end

    // Drive the output beat
    assign o_out.valid      = (r_seq_cnt != '0);
    assign o_out.out_byte   = r_seq_word[BYTE_W-1:0];
    assign o_out.out_index  = r_seq_idx;
    assign o_out.run_last   = (r_seq_cnt == CNT_W'(1));
    assign o_out.image_last = r_seq_img && (r_seq_cnt == CNT_W'(1));

    // Checks
    `MBL_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, rd_en && wr_en,
        rd_addr != r_s1_addr, "page store read and write hit one entry")
    `MBL_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_go,
        r_s1_valid && $stable(r_rd_data), "merge stage lost its read data while stalled")
    `MBL_ASSERT_NEXT(a_burst_load, i_clk, i_rst_n, s1_go && (r_s1.n_bytes != '0),
        r_seq_cnt == $past(r_s1.n_bytes), "burst count not loaded from merge stage")

endmodule

// File: test/mono_bitmap_to_lcd_bytes_test.sv
`timescale 1ns / 100ps

module mono_bitmap_to_lcd_bytes_test;
    import mbl_pkg::*;

    localparam int unsigned MAX_W         = 256;
    localparam int unsigned MAX_H         = 256;
    localparam int unsigned PAGE_COLS     = (MAX_W + 7) / 8;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned RANDOM_ITEMS  = 120;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    // Index past the register list: written to prove it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [BYTE_W-1:0]  out_byte;
        logic [INDEX_W-1:0] out_index;
        logic               run_last;
        logic               image_last;
    } t_lcd_beat;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 src_valid = 1'b0;
    logic [BYTE_W-1:0]    src_byte  = '0;
    logic                 snk_ready = 1'b0;

    mbl_in_if  in_if ();
    mbl_out_if out_if ();

    assign in_if.valid     = src_valid;
    assign in_if.row_byte  = src_byte;
    assign out_if.ready    = snk_ready;

    mono_bitmap_to_lcd_bytes dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pending bitmap bytes and display bytes still owed by the block
    logic [BYTE_W-1:0] pending_q [$];
    t_lcd_beat         lcd_expect_q [$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_epoch   = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    // Converter copy: registers, counters and page store
    logic [DIM_W-1:0]  cfg_width  = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0]  cfg_height = RST_IMAGE_HEIGHT;
    logic              cfg_orient = ORIENT_VERTICAL;
    int unsigned       cur_row    = 0;
    int unsigned       cur_col    = 0;
    logic [WORD_W-1:0] page_mem [PAGE_COLS];

    initial begin
        foreach (page_mem[i]) page_mem[i] = '0;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Convert one accepted bitmap byte into the display bytes it releases
    function automatic void convert_byte(input logic [BYTE_W-1:0] b);
        int unsigned w, h, used, rowlen, pr, col, n;
        bit          last_row;
        t_lcd_beat   burst [8];
        w        = clamp_dim(32'(cfg_width), MAX_W);
        h        = clamp_dim(32'(cfg_height), MAX_H);
        used     = (w + 7) / 8;
        rowlen   = ((w + 31) / 32) * 4;
        last_row = (cur_row == h - 1);
        n        = 0;
        if (cur_col < used) begin
            if (cfg_orient == ORIENT_HORIZONTAL) begin
                burst[0].out_byte   = b;
                burst[0].out_index  = INDEX_W'(cur_row * used + cur_col);
                burst[0].image_last = last_row && (cur_col == used - 1);
                n = 1;
            end else if (cur_col < PAGE_COLS) begin
                pr = cur_row % 8;
                if (pr == 0) page_mem[cur_col] = '0;
                for (int k = 0; k < 8; k++) begin
                    if (b[7-k]) page_mem[cur_col][k*8+pr] = 1'b1;
                end
                // Page complete or image ends: release one byte per column
                if (pr == 7 || last_row) begin
                    for (int k = 0; k < 8; k++) begin
                        col = 8 * cur_col + k;
                        if (col < w) begin
                            burst[n].out_byte   = page_mem[cur_col][8*k +: 8];
                            burst[n].out_index  = INDEX_W'((cur_row / 8) * w + col);
                            burst[n].image_last = last_row && (col == w - 1);
                            n++;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            burst[i].run_last = (i == n - 1);
            lcd_expect_q.push_back(burst[i]);
        end
        // Advance byte and row counters, wrap after the image
        cur_col++;
        if (cur_col >= rowlen) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < MAX_REPORTS) begin
            $display("mismatch %s: got 0x%0h, want 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
        end
        error_count++;
    endtask

    // Driver: offer pending bytes, hold a beat until taken, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && in_if.ready) convert_byte(src_byte);
            if (!src_valid || in_if.ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    src_valid <= 1'b1;
                    src_byte  <= pending_q.pop_front();
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin : receiver
        int unsigned hold_left;
        int unsigned hold_seen;
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else if (hold_left != 0) begin
            snk_ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_epoch) begin
            hold_seen = hold_epoch;
            hold_left = LONG_HOLD;
            snk_ready <= 1'b0;
        end else begin
            snk_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Monitor: compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_lcd_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (lcd_expect_q.size() == 0) begin
                report_mismatch("unexpected beat, index", 32'(out_if.out_index), 0);
            end else begin
                want = lcd_expect_q.pop_front();
                if (out_if.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(out_if.out_byte),
                                    32'(want.out_byte));
                if (out_if.out_index !== want.out_index)
                    report_mismatch("out_index", 32'(out_if.out_index),
                                    32'(want.out_index));
                if (out_if.run_last !== want.run_last)
                    report_mismatch("run_last", 32'(out_if.run_last),
                                    32'(want.run_last));
                if (out_if.image_last !== want.image_last)
                    report_mismatch("image_last", 32'(out_if.image_last),
                                    32'(want.image_last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] rand_pixel_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixels(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) pending_q.push_back(rand_pixel_byte());
    endtask

    // Wait until every byte is taken and every result seen, then let the block settle
    task automatic wait_drained();
        while (pending_q.size() != 0 || src_valid || lcd_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = data;
            REG_IMAGE_HEIGHT: cfg_height = data;
            REG_ORIENTATION:  cfg_orient = data[0];
            default: ;
        endcase
        // Any listed register restarts the image
        if (idx != REG_UNUSED) begin
            cur_row = 0;
            cur_col = 0;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic orient);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_ORIENTATION, {{(DIM_W-1){1'b0}}, orient});
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] corner_bytes [6];
        logic [DIM_W-1:0]  w, h;
        logic              orient;
        int unsigned       wc, hc, n_bytes, fed;
        corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
        src_idle_pct = 27;
        snk_idle_pct = 82;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, vertical: first rows only fill the page store
        for (int i = 0; i < 4; i++) pending_q.push_back(corner_bytes[i]);
        wait_drained();

        // Horizontal with the reset width: bytes pass straight through
        write_reg(REG_ORIENTATION, DIM_W'(ORIENT_HORIZONTAL));
        foreach (corner_bytes[i]) pending_q.push_back(corner_bytes[i]);
        wait_drained();

        // Index past the list: counters keep running
        write_reg(REG_UNUSED, DIM_W'($urandom_range(0, 511)));
        queue_pixels(2);
        wait_drained();

        // Zero sizes clamp to one pixel: each padded row is a whole image
        load_image('0, '0, ORIENT_VERTICAL);
        for (int i = 0; i < 8; i++) pending_q.push_back(corner_bytes[i % 6]);

        // Random images over three idling regimes
        fed = 0;
        for (int regime = 0; regime < 3; regime++) begin
            wait_drained();
            case (regime)
                0:       begin src_idle_pct = 27; snk_idle_pct = 82; end
                1:       begin src_idle_pct = 82; snk_idle_pct = 27; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            if (regime == 2) begin
                // Long receiver hold-off against a dense horizontal row
                load_image(DIM_W'(MAX_W), DIM_W'(2), ORIENT_HORIZONTAL);
                hold_epoch++;
                queue_pixels(32);
            end
            while (fed < (regime + 1) * RANDOM_ITEMS / 3) begin
                case ($urandom_range(0, 9))
                    0:       w = '0;
                    1:       w = DIM_W'($urandom_range(MAX_W + 1, 511));
                    2:       w = DIM_W'($urandom_range(41, MAX_W));
                    default: w = DIM_W'($urandom_range(1, 40));
                endcase
                wc = clamp_dim(32'(w), MAX_W);
                if (wc > 40)                      h = DIM_W'($urandom_range(1, 4));
                else if ($urandom_range(0, 9) == 0) h = '0;
                else                              h = DIM_W'($urandom_range(1, 20));
                hc = clamp_dim(32'(h), MAX_H);
                orient = 1'($urandom_range(0, 1));
                load_image(w, h, orient);
                n_bytes = ((wc + 31) / 32) * 4 * hc;
                // Mostly whole images; some cut short, some running into the next
                case ($urandom_range(0, 9))
                    0, 1:    n_bytes = $urandom_range(1, n_bytes);
                    2:       n_bytes = n_bytes + $urandom_range(1, n_bytes);
                    default: ;
                endcase
                queue_pixels(n_bytes);
                fed += n_bytes;
            end
        end

        // Largest sizes: a full-width one-row page, then one page of an over-tall image
        load_image(DIM_W'(MAX_W), DIM_W'(1), ORIENT_VERTICAL);
        queue_pixels(32);
        load_image(DIM_W'(1), DIM_W'(300), ORIENT_VERTICAL);
        queue_pixels(4 * 8);
        wait_drained();

        if (error_count == 0 && lcd_expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: mono_bitmap_to_lcd_bytes.f
+incdir+hw/rtl
hw/rtl/mbl_pkg.sv
hw/rtl/mbl_in_if.sv
hw/rtl/mbl_out_if.sv
hw/rtl/mono_bitmap_to_lcd_bytes.sv
test/mono_bitmap_to_lcd_bytes_test.sv
